@@ hw/rtl/spt_pkg.sv @@
// spt_pkg: shared types for the sliding Pearson template matcher.
// Used by spt_front, spt_core and sliding_pearson_template_match.
`timescale 1ns / 1ps

package spt_pkg;

    localparam int unsigned IDX_BITS = 6;
    localparam int unsigned LEN_BITS = 7;
    localparam int unsigned CORR_BITS = 16;
    localparam int unsigned LEN_RESET = 64;

    typedef enum logic [1:0] {
        K_TPL,
        K_RESTART,
        K_SAMPLE
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [IDX_BITS-1:0]  idx;
    } t_cmd;

endpackage

@@ hw/rtl/spt_front.sv @@
// spt_front: accepts input requests, classifies them and queues them (2 deep).
// Depends on spt_pkg.
`timescale 1ns / 1ps

module spt_front #(
    parameter int MAX_TEMPLATE = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_mode,
    input  logic [spt_pkg::IDX_BITS-1:0]  i_idx,
    input  logic [SAMPLE_BITS-1:0]        i_value,
    output logic                          o_q_valid,
    output spt_pkg::t_cmd                 o_q_cmd,
    output logic [SAMPLE_BITS-1:0]        o_q_value,
    input  logic                          i_q_ready
);

    spt_pkg::t_cmd            r_cmd [2];
    logic [SAMPLE_BITS-1:0]   r_val [2];
    logic [1:0]               r_cnt;
    logic                     r_rd;
    logic                     r_wr;
    spt_pkg::t_cmd            w_cmd;
    logic                     w_push;
    logic                     w_pop;

    always_comb begin
        w_cmd.idx = i_idx;
        if (i_mode) begin
            w_cmd.kind = spt_pkg::K_SAMPLE;
        end else if (32'(i_idx) < MAX_TEMPLATE) begin
            w_cmd.kind = spt_pkg::K_TPL;
        end else begin
            w_cmd.kind = spt_pkg::K_RESTART;
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_pop     = o_q_valid && i_q_ready;
    assign o_q_cmd   = r_cmd[r_rd];
    assign o_q_value = r_val[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (w_push) begin
                r_cmd[r_wr] <= w_cmd;
                r_val[r_wr] <= i_value;
                r_wr        <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

@@ hw/rtl/spt_core.sv @@
// spt_core: window and template stores, correlation sequencer, square root,
// divider and output register. Depends on spt_pkg.
`timescale 1ns / 1ps

module spt_core #(
    parameter int MAX_TEMPLATE = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [spt_pkg::LEN_BITS-1:0]   i_cfg_len,
    input  logic                           i_q_valid,
    input  spt_pkg::t_cmd                  i_q_cmd,
    input  logic [SAMPLE_BITS-1:0]         i_q_value,
    output logic                           o_q_ready,
    output logic                           o_valid,
    output logic [spt_pkg::CORR_BITS-1:0]  o_corr,
    output logic                           o_flat,
    input  logic                           i_ready
);

    localparam int IW  = (MAX_TEMPLATE > 2) ? $clog2(MAX_TEMPLATE) : 1;
    localparam int NW  = $clog2(MAX_TEMPLATE + 1);
    localparam int SW  = SAMPLE_BITS + NW;
    localparam int XW  = SAMPLE_BITS + NW + 1;
    localparam int PW  = 2 * XW;
    localparam int AW  = PW + NW;
    localparam int NRW = (AW > 33) ? AW : 33;

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_TSUM, S_ACC, S_NORM, S_MUL, S_SQRT, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state                     r_state;
    logic signed [SAMPLE_BITS-1:0] r_win [MAX_TEMPLATE];
    logic signed [SAMPLE_BITS-1:0] r_tpl [MAX_TEMPLATE];
    logic signed [SAMPLE_BITS-1:0] r_wdata;
    logic signed [SAMPLE_BITS-1:0] r_tdata;
    logic signed [SAMPLE_BITS-1:0] r_val;
    logic [NW-1:0]              r_n;
    logic [NW-1:0]              r_fill;
    logic [NW-1:0]              r_k;
    logic [IW-1:0]              r_wp;
    logic [IW-1:0]              r_ri;
    logic signed [SW-1:0]       r_sum;
    logic signed [SW-1:0]       r_tsum;
    logic                       r_tsum_ok;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic signed [XW-1:0]       r_x;
    logic signed [XW-1:0]       r_y;
    logic signed [PW-1:0]       r_pxx;
    logic signed [PW-1:0]       r_pyy;
    logic signed [PW-1:0]       r_pxy;
    logic signed [AW-1:0]       r_axx;
    logic signed [AW-1:0]       r_ayy;
    logic signed [AW-1:0]       r_axy;
    logic [NRW-1:0]             r_px;
    logic [NRW-1:0]             r_py;
    logic [NRW-1:0]             r_m;
    logic                       r_neg;
    logic [63:0]                r_rem;
    logic [63:0]                r_root;
    logic [63:0]                r_bit;
    logic [31:0]                r_div;
    logic [47:0]                r_dq;
    logic [32:0]                r_drem;
    logic [5:0]                 r_cnt;
    logic [spt_pkg::CORR_BITS-1:0] r_res;
    logic                       r_res_flat;
    logic                       r_ov;
    logic [spt_pkg::CORR_BITS-1:0] r_corr;
    logic                       r_flat;

    logic                       w_pop;
    logic                       w_tpl_we;
    logic [IW+spt_pkg::IDX_BITS-1:0] w_ti_ext;
    logic [IW-1:0]              w_win_ra;
    logic                       w_full;
    logic [NW-1:0]              w_fill_nx;
    logic [IW-1:0]              w_wp_nx;
    logic [IW-1:0]              w_ri_nx;
    logic [NW-1:0]              w_len;
    logic signed [XW-1:0]       w_ns;
    logic signed [XW-1:0]       w_nx;
    logic signed [XW-1:0]       w_ny;
    logic                       w_hx;
    logic                       w_hy;
    logic [63:0]                w_sq_t;
    logic [32:0]                w_dt;
    logic [47:0]                w_q;

    assign o_q_ready = (r_state == S_IDLE);
    assign w_pop     = i_q_valid && o_q_ready;
    assign w_tpl_we  = w_pop && (i_q_cmd.kind == spt_pkg::K_TPL);
    assign w_ti_ext  = (IW + spt_pkg::IDX_BITS)'(i_q_cmd.idx);
    assign w_win_ra  = (r_state == S_ACC) ? r_ri : r_wp;

    assign w_full    = (r_fill == r_n);
    assign w_fill_nx = w_full ? r_n : r_fill + NW'(1);
    assign w_wp_nx   = (NW'(r_wp) == r_n - NW'(1)) ? IW'(0) : r_wp + IW'(1);
    assign w_ri_nx   = (NW'(r_ri) == r_n - NW'(1)) ? IW'(0) : r_ri + IW'(1);

    always_comb begin
        if (32'(i_cfg_len) < 2) begin
            w_len = NW'(2);
        end else if (32'(i_cfg_len) > MAX_TEMPLATE) begin
            w_len = NW'(MAX_TEMPLATE);
        end else begin
            w_len = NW'(i_cfg_len);
        end
    end

    assign w_ns = XW'($signed({1'b0, r_n}));
    assign w_nx = XW'(r_wdata) * w_ns - XW'(r_sum);
    assign w_ny = XW'(r_tdata) * w_ns - XW'(r_tsum);

    assign w_hx   = |r_px[NRW-1:32];
    assign w_hy   = |r_py[NRW-1:32];
    assign w_sq_t = r_root + r_bit;
    assign w_dt   = {r_drem[31:0], r_dq[47]};
    assign w_q    = 48'((49'(r_dq) + 49'd1) >> 1);

    // window store
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_win[r_wp] <= r_val;
        end
        r_wdata <= r_win[w_win_ra];
    end

    // template store
    always_ff @(posedge i_clk) begin
        if (w_tpl_we) begin
            r_tpl[w_ti_ext[IW-1:0]] <= $signed(i_q_value);
        end
        r_tdata <= r_tpl[r_k[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_n       <= NW'(spt_pkg::LEN_RESET > MAX_TEMPLATE ? MAX_TEMPLATE
                                                              : spt_pkg::LEN_RESET);
            r_fill    <= '0;
            r_wp      <= '0;
            r_sum     <= '0;
            r_tsum_ok <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_ov      <= 1'b0;
            r_k       <= '0;
        end else begin
            if (r_ov && i_ready && r_state != S_OUT) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                r_n       <= w_len;
                r_fill    <= '0;
                r_wp      <= '0;
                r_sum     <= '0;
                r_tsum_ok <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        case (i_q_cmd.kind)
                            spt_pkg::K_SAMPLE: begin
                                r_val   <= $signed(i_q_value);
                                r_state <= S_UPD;
                            end
                            spt_pkg::K_TPL: begin
                                r_fill    <= '0;
                                r_wp      <= '0;
                                r_sum     <= '0;
                                r_tsum_ok <= 1'b0;
                            end
                            default: begin
                                r_fill <= '0;
                                r_wp   <= '0;
                                r_sum  <= '0;
                            end
                        endcase
                    end
                end
                S_UPD: begin
                    r_sum  <= r_sum - (w_full ? SW'(r_wdata) : SW'(0)) + SW'(r_val);
                    r_fill <= w_fill_nx;
                    r_wp   <= w_wp_nx;
                    r_ri   <= w_wp_nx;
                    r_k    <= '0;
                    r_axx  <= '0;
                    r_ayy  <= '0;
                    r_axy  <= '0;
                    r_tsum <= r_tsum_ok ? r_tsum : SW'(0);
                    if (w_fill_nx != r_n) begin
                        r_state <= S_IDLE;
                    end else if (r_tsum_ok) begin
                        r_state <= S_ACC;
                    end else begin
                        r_state <= S_TSUM;
                    end
                end
                S_TSUM: begin
                    r_v1 <= (r_k != r_n);
                    if (r_k != r_n) begin
                        r_k <= r_k + NW'(1);
                    end
                    if (r_v1) begin
                        r_tsum <= r_tsum + SW'(r_tdata);
                    end
                    if (r_k == r_n && !r_v1) begin
                        r_k       <= '0;
                        r_tsum_ok <= 1'b1;
                        r_state   <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_v1 <= (r_k != r_n);
                    if (r_k != r_n) begin
                        r_k  <= r_k + NW'(1);
                        r_ri <= w_ri_nx;
                    end
                    r_v2  <= r_v1;
                    r_x   <= w_nx;
                    r_y   <= w_ny;
                    r_v3  <= r_v2;
                    r_pxx <= r_x * r_x;
                    r_pyy <= r_y * r_y;
                    r_pxy <= r_x * r_y;
                    if (r_v3) begin
                        r_axx <= r_axx + AW'(r_pxx);
                        r_ayy <= r_ayy + AW'(r_pyy);
                        r_axy <= r_axy + AW'(r_pxy);
                    end
                    if (r_k == r_n && !r_v1 && !r_v2 && !r_v3) begin
                        r_k   <= '0;
                        r_px  <= NRW'($unsigned(r_axx));
                        r_py  <= NRW'($unsigned(r_ayy));
                        r_neg <= r_axy[AW-1];
                        r_m   <= NRW'($unsigned(r_axy[AW-1] ? -r_axy : r_axy));
                        if (r_axx == '0 || r_ayy == '0) begin
                            r_res      <= '0;
                            r_res_flat <= 1'b1;
                            r_state    <= S_OUT;
                        end else begin
                            r_state <= S_NORM;
                        end
                    end
                end
                S_NORM: begin
                    if (w_hx) begin
                        r_px <= r_px >> 2;
                    end
                    if (w_hy) begin
                        r_py <= r_py >> 2;
                    end
                    r_m <= r_m >> (32'(w_hx) + 32'(w_hy));
                    if (!w_hx && !w_hy) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rem   <= 64'(r_px[31:0]) * 64'(r_py[31:0]);
                    r_root  <= '0;
                    r_bit   <= 64'd1 << 62;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_rem >= w_sq_t) begin
                        r_rem  <= r_rem - w_sq_t;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                        r_drem  <= '0;
                        r_dq    <= {r_m[31:0], 16'd0};
                        if (r_rem >= w_sq_t) begin
                            r_div <= 32'((r_root >> 1) + r_bit);
                        end else begin
                            r_div <= (r_root[32:1] == '0) ? 32'd1 : r_root[32:1];
                        end
                    end
                end
                S_DIV: begin
                    if (w_dt >= 33'(r_div)) begin
                        r_drem <= w_dt - 33'(r_div);
                        r_dq   <= {r_dq[46:0], 1'b1};
                    end else begin
                        r_drem <= w_dt;
                        r_dq   <= {r_dq[46:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd47) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res_flat <= 1'b0;
                    if (r_neg) begin
                        r_res <= (w_q > 48'd32768) ? 16'h8000 : 16'(-w_q);
                    end else begin
                        r_res <= (w_q > 48'd32767) ? 16'h7FFF : w_q[15:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_ov    <= 1'b1;
                        r_corr  <= r_res;
                        r_flat  <= r_res_flat;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_corr  = r_corr;
    assign o_flat  = r_flat;

endmodule

@@ hw/rtl/sliding_pearson_template_match.sv @@
// Sliding Pearson template matcher, top level.
// Instantiates spt_front and spt_core; depends on spt_pkg.
//
// Input stream: tuser = mode (0 template word, 1 data sample); tdata holds
// template_index then value. A template word lands in the template store and
// restarts the window. Samples fill a ring window of the programmed length;
// once full each sample gives one result: tdata = correlation (Q1.15),
// tuser = flat_window (zero variance, correlation 0).
// i_cfg_we/i_cfg_wdata write the window length (clamped to 2..MAX_TEMPLATE)
// and restart the window; write only while the block is idle.
// Steps: a sample that gives no result only updates the window; one that
// gives a result runs a window pass, normalise steps, 32 square-root steps
// and a 48-step divider. After a template or length change one extra pass
// sums the template. Input requests queue 2 deep ahead of the sequencer,
// and one finished result waits in the output register while the receiver
// stalls.
// Reset: window empty, length 64; template contents undefined until written.
`timescale 1ns / 1ps

module sliding_pearson_template_match #(
    parameter int MAX_TEMPLATE = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // template_index [5:0], value [6+SAMPLE_BITS-1:6], zero fill
    input  logic [((spt_pkg::IDX_BITS+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // correlation [15:0]
    output logic [15:0]          m_axis_tdata,
    // flat_window
    output logic                 m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [spt_pkg::LEN_BITS-1:0] i_cfg_wdata
);

    localparam int IB = spt_pkg::IDX_BITS;

    logic                    w_q_valid;
    logic                    w_q_ready;
    spt_pkg::t_cmd           w_q_cmd;
    logic [SAMPLE_BITS-1:0]  w_q_value;

    spt_front #(
        .MAX_TEMPLATE (MAX_TEMPLATE),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_mode    (s_axis_tuser),
        .i_idx     (s_axis_tdata[IB-1:0]),
        .i_value   (s_axis_tdata[IB+SAMPLE_BITS-1:IB]),
        .o_q_valid (w_q_valid),
        .o_q_cmd   (w_q_cmd),
        .o_q_value (w_q_value),
        .i_q_ready (w_q_ready)
    );

    spt_core #(
        .MAX_TEMPLATE (MAX_TEMPLATE),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_len (i_cfg_wdata),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .i_q_value (w_q_value),
        .o_q_ready (w_q_ready),
        .o_valid   (m_axis_tvalid),
        .o_corr    (m_axis_tdata),
        .o_flat    (m_axis_tuser),
        .i_ready   (m_axis_tready)
    );

endmodule
